// File: hdl/hhst_pkg.sv
package hhst_pkg;

   localparam int CNT_W  = 48;
   localparam int SITE_W = 32;
   localparam int SIZE_W = 32;

   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   localparam logic CMD_RECORD = 1'b0;
   localparam logic CMD_REPORT = 1'b1;

   typedef logic [2:0] cell_op_type;

   localparam cell_op_type CELL_HOLD      = 3'd0;
   localparam cell_op_type CELL_MIN_STEP  = 3'd1;
   localparam cell_op_type CELL_RANK_INIT = 3'd2;
   localparam cell_op_type CELL_ROT_STEP  = 3'd3;
   localparam cell_op_type CELL_ADD       = 3'd4;
   localparam cell_op_type CELL_FILL      = 3'd5;
   localparam cell_op_type CELL_CUT       = 3'd6;

   typedef struct packed {
      cell_op_type        op;
      logic [SIZE_W-1:0]  size;
      logic [CNT_W-1:0]   dec;
   } cell_ctrl_type;

   typedef struct packed {
      logic               occ;
      logic               hit;
      logic               pick;
      logic [CNT_W-1:0]   count;
   } cell_stat_type;

   function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                input logic [CNT_W-1:0] b);
      logic [CNT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
   endfunction

endpackage

// File: hdl/hhst_req_if.sv
interface hhst_req_if;
   logic                        valid;
   logic                        ready;
   logic                        cmd;
   logic [hhst_pkg::SITE_W-1:0] site;
   logic [hhst_pkg::SIZE_W-1:0] size;

   modport source (output valid, cmd, site, size, input ready);
   modport sink (input valid, cmd, site, size, output ready);
endinterface

// File: hdl/hhst_rsp_if.sv
interface hhst_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [hhst_pkg::SITE_W-1:0] site_res;
   logic [hhst_pkg::CNT_W-1:0]  bytes;
   logic                        valid_res;
   logic [hhst_pkg::CNT_W-1:0]  total;
   logic                        last;

   modport source (output valid, site_res, bytes, valid_res, total, last, input ready);
   modport sink (input valid, site_res, bytes, valid_res, total, last, output ready);
endinterface

// File: hdl/hhst_cell.sv
module hhst_cell #(
   parameter int IW    = 3,
   parameter int SW    = 32,
   parameter int INDEX = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  hhst_pkg::cell_ctrl_type       ctrl,
   input  logic                          sel,
   input  logic [SW-1:0]                 req_site,
   input  logic [IW-1:0]                 emit_rank,
   input  logic [hhst_pkg::CNT_W-1:0]    left_cnt,
   input  logic [IW-1:0]                 left_idx,
   output logic [hhst_pkg::CNT_W-1:0]    pass_cnt,
   output logic [IW-1:0]                 pass_idx,
   output logic [SW-1:0]                 site,
   output hhst_pkg::cell_stat_type       stat
);

   localparam logic [IW-1:0] MY_IDX = IW'(INDEX);
   localparam bit FIRST = (INDEX == 0);

   logic                       occ_ff, occ_in;
   logic [hhst_pkg::CNT_W-1:0] count_ff, count_in;
   logic [SW-1:0]              site_ff, site_in;
   logic                       hit_ff, hit_in;
   logic [IW-1:0]              rank_ff, rank_in;
   logic [hhst_pkg::CNT_W-1:0] pass_cnt_ff, pass_cnt_in;
   logic [IW-1:0]              pass_idx_ff, pass_idx_in;
   logic                       beats;

   // incoming entry outranks this one: larger count, or equal count from a lower slot
   assign beats = (left_cnt > count_ff) || ((left_cnt == count_ff) && (left_idx < MY_IDX));

   always_comb begin
      occ_in      = occ_ff;
      count_in    = count_ff;
      site_in     = site_ff;
      hit_in      = hit_ff;
      rank_in     = rank_ff;
      pass_cnt_in = pass_cnt_ff;
      pass_idx_in = pass_idx_ff;
      unique case (ctrl.op)
         hhst_pkg::CELL_HOLD: begin
         end
         hhst_pkg::CELL_MIN_STEP: begin
            hit_in = occ_ff && (site_ff == req_site);
            if (FIRST || (count_ff < left_cnt)) begin
               pass_cnt_in = count_ff;
               pass_idx_in = MY_IDX;
            end else begin
               pass_cnt_in = left_cnt;
               pass_idx_in = left_idx;
            end
         end
         hhst_pkg::CELL_RANK_INIT: begin
            pass_cnt_in = count_ff;
            pass_idx_in = MY_IDX;
            rank_in     = '0;
         end
         hhst_pkg::CELL_ROT_STEP: begin
            pass_cnt_in = left_cnt;
            pass_idx_in = left_idx;
            if (beats) begin
               rank_in = rank_ff + IW'(1);
            end
         end
         hhst_pkg::CELL_ADD: begin
            if (sel) begin
               count_in = hhst_pkg::sat_add(count_ff, hhst_pkg::CNT_W'(ctrl.size));
            end
         end
         hhst_pkg::CELL_FILL: begin
            if (sel) begin
               occ_in   = 1'b1;
               site_in  = req_site;
               count_in = hhst_pkg::CNT_W'(ctrl.size);
            end
         end
         hhst_pkg::CELL_CUT: begin
            if (sel) begin
               site_in  = req_site;
               count_in = hhst_pkg::CNT_W'(ctrl.size);
            end else begin
               count_in = count_ff - ctrl.dec;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff   <= 1'b0;
         count_ff <= '0;
      end else begin
         occ_ff   <= occ_in;
         count_ff <= count_in;
      end
      site_ff     <= site_in;
      hit_ff      <= hit_in;
      rank_ff     <= rank_in;
      pass_cnt_ff <= pass_cnt_in;
      pass_idx_ff <= pass_idx_in;
   end

   assign pass_cnt   = pass_cnt_ff;
   assign pass_idx   = pass_idx_ff;
   assign site       = site_ff;
   assign stat.occ   = occ_ff;
   assign stat.hit   = hit_ff;
   assign stat.pick  = (rank_ff == emit_rank);
   assign stat.count = count_ff;

endmodule

// File: hdl/heavy_hitter_site_tracker.sv
// Weighted frequent-site summary over ENTRIES slots held in a row of cells. A record
// request (cmd 0) adds size to the running total and credits the site's slot, opens
// the next free slot, or, when all slots are full, cuts every count by the smaller of
// size and the smallest count and hands that minimum slot to the site if size reaches
// it. A record gives no response and holds ready low while the minimum ripples down
// the cell chain, then through a decide step and an update step. A report request
// (cmd 1) gives ENTRIES responses ranked by count, highest first, ties to the lower
// slot, each with count plus eliminated sum; the rank is formed by rotating every
// count once around the chain, after which one response leaves per cycle while the
// sink is ready. Ready comes back once the last response is in the output register.
module heavy_hitter_site_tracker #(
   parameter int ENTRIES   = 5,
   parameter int SITE_BITS = 32
) (
   input  logic              clock,
   input  logic              reset,
   hhst_req_if.sink          req_bus,
   hhst_rsp_if.source        rsp_bus
);

   localparam int IW = $clog2(ENTRIES);
   localparam int SW = (SITE_BITS < hhst_pkg::SITE_W) ? SITE_BITS : hhst_pkg::SITE_W;
   localparam int CW = hhst_pkg::CNT_W;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_DECIDE = 3'd2;
   localparam logic [2:0] ST_APPLY  = 3'd3;
   localparam logic [2:0] ST_RANK   = 3'd4;
   localparam logic [2:0] ST_EMIT   = 3'd5;

   logic [2:0]                   state_ff, state_in;
   logic [IW-1:0]                step_ff, step_in;
   logic [SW-1:0]                site_ff, site_in;
   logic [hhst_pkg::SIZE_W-1:0]  size_ff, size_in;
   logic [CW-1:0]                total_ff, total_in;
   logic [CW-1:0]                elim_ff, elim_in;
   logic                         wins_ff, wins_in;
   logic [CW-1:0]                dec_ff, dec_in;
   logic [IW-1:0]                min_idx_ff, min_idx_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [hhst_pkg::SITE_W-1:0]  rsp_site_ff, rsp_site_in;
   logic [CW-1:0]                rsp_bytes_ff, rsp_bytes_in;
   logic                         rsp_ok_ff, rsp_ok_in;
   logic [CW-1:0]                rsp_total_ff, rsp_total_in;
   logic                         rsp_last_ff, rsp_last_in;

   hhst_pkg::cell_ctrl_type      ctrl;
   logic [ENTRIES-1:0]           sel_vec;
   logic [ENTRIES-1:0]           occ_vec;
   logic [ENTRIES-1:0]           hit_vec;
   logic [ENTRIES-1:0]           pick_vec;
   logic [ENTRIES-1:0]           free_vec;
   logic [CW-1:0]                pass_cnt [ENTRIES];
   logic [IW-1:0]                pass_idx [ENTRIES];
   logic [SW-1:0]                cell_site [ENTRIES];
   hhst_pkg::cell_stat_type      stat [ENTRIES];

   logic [CW-1:0]                pick_cnt;
   logic [SW-1:0]                pick_site;
   logic                         pick_occ;
   logic                         pick_ok;

   genvar g;
   generate
      for (g = 0; g < ENTRIES; g++) begin : g_cell
         localparam int LEFT = (g == 0) ? ENTRIES - 1 : g - 1;
         hhst_cell #(
            .IW    (IW),
            .SW    (SW),
            .INDEX (g)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctrl      (ctrl),
            .sel       (sel_vec[g]),
            .req_site  (site_ff),
            .emit_rank (step_ff),
            .left_cnt  (pass_cnt[LEFT]),
            .left_idx  (pass_idx[LEFT]),
            .pass_cnt  (pass_cnt[g]),
            .pass_idx  (pass_idx[g]),
            .site      (cell_site[g]),
            .stat      (stat[g])
         );
         assign occ_vec[g]  = stat[g].occ;
         assign hit_vec[g]  = stat[g].hit;
         assign pick_vec[g] = stat[g].pick;
      end
   endgenerate

   // slots fill from the bottom, so the first free one sits above the last occupied
   always_comb begin
      free_vec[0] = !occ_vec[0];
      for (int k = 1; k < ENTRIES; k++) begin
         free_vec[k] = !occ_vec[k] && occ_vec[k-1];
      end
   end

   always_comb begin
      pick_cnt  = '0;
      pick_site = '0;
      pick_occ  = 1'b0;
      for (int k = 0; k < ENTRIES; k++) begin
         if (pick_vec[k]) begin
            pick_cnt  = pick_cnt | stat[k].count;
            pick_site = pick_site | cell_site[k];
            pick_occ  = pick_occ | stat[k].occ;
         end
      end
   end

   assign pick_ok = pick_occ && (pick_cnt != '0);

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      site_in      = site_ff;
      size_in      = size_ff;
      total_in     = total_ff;
      elim_in      = elim_ff;
      wins_in      = wins_ff;
      dec_in       = dec_ff;
      min_idx_in   = min_idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_site_in  = rsp_site_ff;
      rsp_bytes_in = rsp_bytes_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_total_in = rsp_total_ff;
      rsp_last_in  = rsp_last_ff;
      ctrl.op      = hhst_pkg::CELL_HOLD;
      ctrl.size    = size_ff;
      ctrl.dec     = dec_ff;
      sel_vec      = '0;

      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               site_in = req_bus.site[SW-1:0];
               size_in = req_bus.size;
               step_in = '0;
               if (req_bus.cmd == hhst_pkg::CMD_REPORT) begin
                  ctrl.op  = hhst_pkg::CELL_RANK_INIT;
                  state_in = ST_RANK;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            ctrl.op = hhst_pkg::CELL_MIN_STEP;
            step_in = step_ff + IW'(1);
            if (step_ff == IW'(ENTRIES - 1)) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            min_idx_in = pass_idx[ENTRIES-1];
            wins_in    = !(CW'(size_ff) < pass_cnt[ENTRIES-1]);
            dec_in     = wins_in ? pass_cnt[ENTRIES-1] : CW'(size_ff);
            state_in   = ST_APPLY;
         end
         ST_APPLY: begin
            total_in = hhst_pkg::sat_add(total_ff, CW'(size_ff));
            if (|hit_vec) begin
               ctrl.op = hhst_pkg::CELL_ADD;
               sel_vec = hit_vec;
            end else if (!occ_vec[ENTRIES-1]) begin
               ctrl.op = hhst_pkg::CELL_FILL;
               sel_vec = free_vec;
            end else begin
               ctrl.op = hhst_pkg::CELL_CUT;
               elim_in = hhst_pkg::sat_add(elim_ff, dec_ff);
               for (int k = 0; k < ENTRIES; k++) begin
                  sel_vec[k] = wins_ff && (min_idx_ff == IW'(k));
               end
            end
            state_in = ST_IDLE;
         end
         ST_RANK: begin
            ctrl.op = hhst_pkg::CELL_ROT_STEP;
            step_in = step_ff + IW'(1);
            if (step_ff == IW'(ENTRIES - 2)) begin
               step_in  = '0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = pick_ok;
               rsp_site_in  = pick_ok ? hhst_pkg::SITE_W'(pick_site) : '0;
               rsp_bytes_in = pick_ok ? hhst_pkg::sat_add(pick_cnt, elim_ff) : '0;
               rsp_total_in = total_ff;
               rsp_last_in  = (step_ff == IW'(ENTRIES - 1));
               step_in      = step_ff + IW'(1);
               if (step_ff == IW'(ENTRIES - 1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         total_ff     <= '0;
         elim_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         total_ff     <= total_in;
         elim_ff      <= elim_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      site_ff      <= site_in;
      size_ff      <= size_in;
      wins_ff      <= wins_in;
      dec_ff       <= dec_in;
      min_idx_ff   <= min_idx_in;
      rsp_site_ff  <= rsp_site_in;
      rsp_bytes_ff <= rsp_bytes_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_total_ff <= rsp_total_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign req_bus.ready     = (state_ff == ST_IDLE);
   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.site_res  = rsp_site_ff;
   assign rsp_bus.bytes     = rsp_bytes_ff;
   assign rsp_bus.valid_res = rsp_ok_ff;
   assign rsp_bus.total     = rsp_total_ff;
   assign rsp_bus.last      = rsp_last_ff;

`ifndef SYNTHESIS
   // occupied slots always form an unbroken run from slot zero
   a_occ_prefix: assert property (@(posedge clock) disable iff (reset)
      ((occ_vec & (occ_vec + ENTRIES'(1))) == '0))
      else $error("occupied slots not contiguous");

   // a site is held by at most one slot
   a_hit_unique: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_APPLY) |-> $onehot0(hit_vec))
      else $error("site matched in more than one slot");

   // ranks form a permutation, so every report position names exactly one slot
   a_rank_onehot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> $onehot(pick_vec))
      else $error("report rank not held by exactly one slot");

   // the running total never falls
   a_total_mono: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_APPLY) |=> (total_ff >= $past(total_ff)))
      else $error("total decreased");
`endif

endmodule
